FILE: sv/vfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_pkg: shared types and constants for the vector fixed-point ALU
// Opcodes, pipeline geometry, sideband record and the 32-bit clip helper.
// ----------------------------------------------------------------------------
package vfa_pkg;

    localparam int DATA_W   = 32;
    localparam int LANES    = 4;
    localparam int OPND_W   = DATA_W + 1;        // multiplier operand (b - a fits)
    localparam int PROD_W   = 2 * OPND_W;        // full lane product
    localparam int SUM_W    = PROD_W + 2;        // four products summed
    localparam int ROOT_W   = DATA_W + 1;        // length can reach 2^32
    localparam int RAD_W    = 2 * ROOT_W;        // sqrt radicand
    localparam int SQ_STEPS = ROOT_W;            // one root bit per stage
    localparam int DV_STEPS = ROOT_W;            // one quotient bit per stage

    // sideband positions
    localparam int IDX_RES  = 3;                 // lane results join
    localparam int IDX_SUM  = 4;                 // dot result and magnitudes join
    localparam int IDX_ROOT = IDX_SUM + SQ_STEPS;
    localparam int NSIDE    = IDX_ROOT + DV_STEPS + 1;

    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_MUL   = 4'd2,
        CMD_SCALE = 4'd3,
        CMD_DIV   = 4'd4,
        CMD_DIVS  = 4'd5,
        CMD_DOT   = 4'd6,
        CMD_EQ    = 4'd7,
        CMD_NORM  = 4'd8,
        CMD_SQLEN = 4'd9,
        CMD_LEN   = 4'd10,
        CMD_LERP  = 4'd11
    } cmd_e;

    typedef struct packed {
        logic [DATA_W-1:0] v;
        logic              s;
    } clip_t;

    typedef struct packed {
        logic [3:0]                   cmd;
        logic                         eq;
        logic [LANES-1:0][DATA_W-1:0] a;
        logic [LANES-1:0][DATA_W-1:0] dv;
        logic [LANES-1:0][DATA_W-1:0] res;
        logic [LANES-1:0]             lsat;
        logic [DATA_W-1:0]            sres;
        logic                         ssat;
        logic [LANES-1:0][DATA_W-1:0] amag;
        logic [LANES-1:0][DATA_W-1:0] dvmag;
        logic [LANES-1:0]             aneg;
        logic [LANES-1:0]             dneg;
        logic [ROOT_W-1:0]            root;
    } side_t;

    function automatic clip_t clip32(input logic signed [SUM_W-1:0] v);
        clip_t r;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-DATA_W){1'b0}}, WORD_MAX};
        lo = {{(SUM_W-DATA_W){1'b1}}, WORD_MIN};
        if (v > hi)
        begin
            r.v = WORD_MAX;
            r.s = 1'b1;
        end
        else if (v < lo)
        begin
            r.v = WORD_MIN;
            r.s = 1'b1;
        end
        else
        begin
            r.v = v[DATA_W-1:0];
            r.s = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: sv/vfa_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_lane: one component lane
// Operand select, one multiplier, then shift/add and clip for the
// elementwise ops. The raw product also feeds the dot/length adder tree.
// ----------------------------------------------------------------------------
module vfa_lane import vfa_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [3:0]               cmd,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    input  logic signed [DATA_W-1:0] t,
    output logic [DATA_W-1:0]        res,
    output logic                     sat,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [OPND_W-1:0] x_next, y_next, as_next, d_val;
    logic signed [OPND_W-1:0] x_reg, y_reg, as1_reg, as2_reg;
    logic signed [DATA_W-1:0] a1_reg, a2_reg;
    logic [3:0]               cmd1_reg, cmd2_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] sh;
    clip_t                    c_next;
    logic [DATA_W-1:0]        res_reg;
    logic                     sat_reg;

    always_comb
    begin
        d_val = OPND_W'(b) - OPND_W'(a);
        case (cmd)
            CMD_MUL, CMD_DOT:
            begin
                x_next = OPND_W'(a);
                y_next = OPND_W'(b);
            end
            CMD_SCALE:
            begin
                x_next = OPND_W'(a);
                y_next = OPND_W'(t);
            end
            CMD_LERP:
            begin
                x_next = d_val;
                y_next = OPND_W'(t);
            end
            default:
            begin
                x_next = OPND_W'(a);
                y_next = OPND_W'(a);
            end
        endcase
        if (cmd == CMD_SUB)
            as_next = OPND_W'(a) - OPND_W'(b);
        else
            as_next = OPND_W'(a) + OPND_W'(b);
    end

    always_comb
    begin
        sh = p_reg >>> FRAC_BITS;
        case (cmd2_reg)
            CMD_ADD, CMD_SUB:
                c_next = clip32(SUM_W'(as2_reg));
            CMD_MUL, CMD_SCALE:
                c_next = clip32(SUM_W'(sh));
            CMD_LERP:
                c_next = clip32(SUM_W'(sh) + SUM_W'(a2_reg));
            default:
                c_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            as1_reg  <= as_next;
            a1_reg   <= a;
            cmd1_reg <= cmd;
            p_reg    <= x_reg * y_reg;
            as2_reg  <= as1_reg;
            a2_reg   <= a1_reg;
            cmd2_reg <= cmd1_reg;
            res_reg  <= c_next.v;
            sat_reg  <= c_next.s;
        end
    end

    assign res  = res_reg;
    assign sat  = sat_reg;
    assign prod = p_reg;

endmodule

FILE: sv/vfa_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_sqrt: pipelined integer square root
// Digit-by-digit, one root bit per stage; floor(sqrt(rad)).
// ----------------------------------------------------------------------------
module vfa_sqrt import vfa_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 4;

    logic [REM_W-1:0]  rem_reg  [SQ_STEPS];
    logic [ROOT_W-1:0] root_reg [SQ_STEPS];
    logic [RAD_W-1:0]  rad_reg  [SQ_STEPS];
    logic [REM_W-1:0]  rem_next [SQ_STEPS];
    logic [ROOT_W-1:0] root_next[SQ_STEPS];
    logic [RAD_W-1:0]  rad_next [SQ_STEPS];

    always_comb
    begin
        logic [REM_W-1:0]  r_in;
        logic [ROOT_W-1:0] q_in;
        logic [RAD_W-1:0]  n_in;
        logic [REM_W-1:0]  r2;
        logic [REM_W-1:0]  trial;
        logic              ge;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                r_in = '0;
                q_in = '0;
                n_in = rad;
            end
            else
            begin
                r_in = rem_reg[k-1];
                q_in = root_reg[k-1];
                n_in = rad_reg[k-1];
            end
            r2    = {r_in[REM_W-3:0], n_in[RAD_W-1 -: 2]};
            trial = {2'b00, q_in, 2'b01};
            ge    = (r2 >= trial);
            rem_next[k]  = ge ? (r2 - trial) : r2;
            root_next[k] = {q_in[ROOT_W-2:0], ge};
            rad_next[k]  = {n_in[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign root = root_reg[SQ_STEPS-1];

endmodule

FILE: sv/vfa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_div: pipelined unsigned divider
// Range check up front, then restoring division, one quotient bit per stage.
// Only quotients below 2^33 are formed; larger ones raise ovf.
// ----------------------------------------------------------------------------
module vfa_div import vfa_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [DATA_W+FRAC_BITS-1:0] num,
    input  logic [ROOT_W-1:0]           den,
    output logic [ROOT_W-1:0]           q,
    output logic                        ovf,
    output logic                        den_zero
);

    localparam int NW = DATA_W + FRAC_BITS;

    logic [ROOT_W-1:0] rem_reg [DV_STEPS+1];
    logic [ROOT_W-1:0] q_reg   [DV_STEPS+1];
    logic [ROOT_W-1:0] nlo_reg [DV_STEPS+1];
    logic [ROOT_W-1:0] d_reg   [DV_STEPS+1];
    logic              ovf_reg [DV_STEPS+1];
    logic              dz_reg  [DV_STEPS+1];

    logic [ROOT_W-1:0] rem_next[DV_STEPS+1];
    logic [ROOT_W-1:0] q_next  [DV_STEPS+1];
    logic [ROOT_W-1:0] nlo_next[DV_STEPS+1];
    logic [ROOT_W-1:0] d_next  [DV_STEPS+1];
    logic              ovf_next[DV_STEPS+1];
    logic              dz_next [DV_STEPS+1];

    always_comb
    begin
        logic [ROOT_W:0] r2;
        logic            ge;
        rem_next[0] = ROOT_W'(num[NW-1:ROOT_W]);
        q_next[0]   = '0;
        nlo_next[0] = num[ROOT_W-1:0];
        d_next[0]   = den;
        ovf_next[0] = (ROOT_W'(num[NW-1:ROOT_W]) >= den);
        dz_next[0]  = (den == '0);
        for (int m = 1; m <= DV_STEPS; m++)
        begin
            r2 = {rem_reg[m-1], nlo_reg[m-1][ROOT_W-1]};
            ge = (r2 >= {1'b0, d_reg[m-1]});
            rem_next[m] = ge ? ROOT_W'(r2 - {1'b0, d_reg[m-1]}) : ROOT_W'(r2);
            q_next[m]   = {q_reg[m-1][ROOT_W-2:0], ge};
            nlo_next[m] = {nlo_reg[m-1][ROOT_W-2:0], 1'b0};
            d_next[m]   = d_reg[m-1];
            ovf_next[m] = ovf_reg[m-1];
            dz_next[m]  = dz_reg[m-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            nlo_reg <= nlo_next;
            d_reg   <= d_next;
            ovf_reg <= ovf_next;
            dz_reg  <= dz_next;
        end
    end

    assign q        = q_reg[DV_STEPS];
    assign ovf      = ovf_reg[DV_STEPS];
    assign den_zero = dz_reg[DV_STEPS];

endmodule

FILE: sv/vec4_fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec4_fixed_point_alu: four-component vector ALU, signed fixed point
// Add/sub/mul/scale/div/dot/eq/norm/length/lerp with saturation flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one item (command, vectors a and
//   b, scalar). Output channel: out_valid / out_stall carry one result item.
//   An item is taken on a clock edge with valid high and stall low.
//   The pipeline depth comes from the length/normalize path: 33 square-root
//   stages (one root bit each) followed by 33 divider stages (one quotient
//   bit each), plus operand, multiply and adder-tree stages up front.
//   Throughput is one item per cycle while no valid result is held at a
//   stalled output; every stage is fully pipelined and each lane has its own multiplier and divider.
//   When a valid result is stalled at the output the whole pipeline freezes and
//   in_stall goes high in the same cycle; the held result stays on the output ports.
//   Reset clears all valid bits; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module vec4_fixed_point_alu import vfa_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [3:0]               command,
    input  logic signed [DATA_W-1:0] a_x,
    input  logic signed [DATA_W-1:0] a_y,
    input  logic signed [DATA_W-1:0] a_z,
    input  logic signed [DATA_W-1:0] a_w,
    input  logic signed [DATA_W-1:0] b_x,
    input  logic signed [DATA_W-1:0] b_y,
    input  logic signed [DATA_W-1:0] b_z,
    input  logic signed [DATA_W-1:0] b_w,
    input  logic signed [DATA_W-1:0] scalar,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] out_x,
    output logic signed [DATA_W-1:0] out_y,
    output logic signed [DATA_W-1:0] out_z,
    output logic signed [DATA_W-1:0] out_w,
    output logic signed [DATA_W-1:0] out_scalar,
    output logic                     equal,
    output logic                     saturated,
    output logic                     divide_by_zero
);

    localparam int NW = DATA_W + FRAC_BITS;

    // global advance: everything moves unless a finished result is held
    logic adv;

    logic                         s1_v_reg;
    logic [3:0]                   s1_cmd_reg;
    logic [LANES-1:0][DATA_W-1:0] s1_a_reg, s1_b_reg;
    logic [DATA_W-1:0]            s1_t_reg;

    logic [DATA_W-1:0]        ln_res [LANES];
    logic                     ln_sat [LANES];
    logic signed [PROD_W-1:0] ln_prod[LANES];

    logic signed [SUM_W-1:0] pair_reg [2];
    logic signed [SUM_W-1:0] total_reg;

    side_t            side_reg [NSIDE];
    side_t            side_next[NSIDE];
    logic [NSIDE-1:0] v_reg;

    logic [ROOT_W-1:0] sq_root;

    logic [NW-1:0]     dv_num [LANES];
    logic [ROOT_W-1:0] dv_den [LANES];
    logic [ROOT_W-1:0] dv_q   [LANES];
    logic              dv_ovf [LANES];
    logic              dv_dz  [LANES];

    logic                         out_valid_reg;
    logic [LANES-1:0][DATA_W-1:0] ov_next, ov_reg;
    logic [DATA_W-1:0]            osc_next, osc_reg;
    logic                         oeq_next, oeq_reg;
    logic                         osat_next, osat_reg;
    logic                         odz_next, odz_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= command;
            s1_a_reg   <= {a_w, a_z, a_y, a_x};
            s1_b_reg   <= {b_w, b_z, b_y, b_x};
            s1_t_reg   <= scalar;
        end
    end

    // lanes: operand select, multiply, elementwise result
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        vfa_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .en   (adv),
            .cmd  (s1_cmd_reg),
            .a    (s1_a_reg[l]),
            .b    (s1_b_reg[l]),
            .t    (s1_t_reg),
            .res  (ln_res[l]),
            .sat  (ln_sat[l]),
            .prod (ln_prod[l])
        );
    end

    // merge: two-level adder tree over the lane products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pair_reg[0] <= SUM_W'(ln_prod[0]) + SUM_W'(ln_prod[1]);
            pair_reg[1] <= SUM_W'(ln_prod[2]) + SUM_W'(ln_prod[3]);
            total_reg   <= pair_reg[0] + pair_reg[1];
        end
    end

    // square root of the raw sum of squares
    vfa_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (total_reg[RAD_W-1:0]),
        .root (sq_root)
    );

    // per-lane dividers: div / divscalar by b or t, normalize by the length
    for (genvar l = 0; l < LANES; l++)
    begin : g_div
        assign dv_num[l] = {side_reg[IDX_ROOT-1].amag[l], {FRAC_BITS{1'b0}}};
        assign dv_den[l] = (side_reg[IDX_ROOT-1].cmd == CMD_NORM) ? sq_root
                         : {1'b0, side_reg[IDX_ROOT-1].dvmag[l]};
        vfa_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk      (clk),
            .en       (adv),
            .num      (dv_num[l]),
            .den      (dv_den[l]),
            .q        (dv_q[l]),
            .ovf      (dv_ovf[l]),
            .den_zero (dv_dz[l])
        );
    end

    // sideband delay line, with results merged in where they appear
    always_comb
    begin
        clip_t dc;
        side_next[0]     = '0;
        side_next[0].cmd = s1_cmd_reg;
        side_next[0].eq  = (s1_a_reg == s1_b_reg);
        side_next[0].a   = s1_a_reg;
        case (s1_cmd_reg)
            CMD_DIV:  side_next[0].dv = s1_b_reg;
            CMD_DIVS: side_next[0].dv = {LANES{s1_t_reg}};
            default:  side_next[0].dv = '0;
        endcase
        for (int j = 1; j < NSIDE; j++)
            side_next[j] = side_reg[j-1];

        for (int l = 0; l < LANES; l++)
        begin
            side_next[IDX_RES].res[l]  = ln_res[l];
            side_next[IDX_RES].lsat[l] = ln_sat[l];
        end

        dc = clip32(total_reg >>> FRAC_BITS);
        if (side_reg[IDX_SUM-1].cmd == CMD_DOT || side_reg[IDX_SUM-1].cmd == CMD_SQLEN)
        begin
            side_next[IDX_SUM].sres = dc.v;
            side_next[IDX_SUM].ssat = dc.s;
        end
        for (int l = 0; l < LANES; l++)
        begin
            side_next[IDX_SUM].aneg[l]  = side_reg[IDX_SUM-1].a[l][DATA_W-1];
            side_next[IDX_SUM].dneg[l]  = side_reg[IDX_SUM-1].dv[l][DATA_W-1];
            side_next[IDX_SUM].amag[l]  = side_reg[IDX_SUM-1].a[l][DATA_W-1]
                                        ? (~side_reg[IDX_SUM-1].a[l] + 1'b1)
                                        : side_reg[IDX_SUM-1].a[l];
            side_next[IDX_SUM].dvmag[l] = side_reg[IDX_SUM-1].dv[l][DATA_W-1]
                                        ? (~side_reg[IDX_SUM-1].dv[l] + 1'b1)
                                        : side_reg[IDX_SUM-1].dv[l];
        end

        side_next[IDX_ROOT].root = sq_root;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            side_reg <= side_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NSIDE-2:0], s1_v_reg};
    end

    // final select: pick the result kind by opcode, resolve quotient signs
    always_comb
    begin
        side_t sr;
        logic  neg;
        sr        = side_reg[NSIDE-1];
        ov_next   = '0;
        osc_next  = '0;
        oeq_next  = 1'b0;
        osat_next = 1'b0;
        odz_next  = 1'b0;
        neg       = 1'b0;
        case (sr.cmd)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_SCALE, CMD_LERP:
            begin
                ov_next   = sr.res;
                osat_next = |sr.lsat;
            end
            CMD_DIV, CMD_DIVS, CMD_NORM:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    neg = sr.aneg[l] ^ sr.dneg[l];
                    if (dv_dz[l])
                    begin
                        ov_next[l] = sr.aneg[l] ? WORD_MIN : WORD_MAX;
                        odz_next   = 1'b1;
                    end
                    else if (dv_ovf[l] || (!neg && dv_q[l] > {1'b0, WORD_MAX})
                             || (neg && dv_q[l] > {1'b0, WORD_MIN}))
                    begin
                        ov_next[l] = neg ? WORD_MIN : WORD_MAX;
                        osat_next  = 1'b1;
                    end
                    else
                    begin
                        ov_next[l] = neg ? (~dv_q[l][DATA_W-1:0] + 1'b1)
                                   : dv_q[l][DATA_W-1:0];
                    end
                end
            end
            CMD_DOT, CMD_SQLEN:
            begin
                osc_next  = sr.sres;
                osat_next = sr.ssat;
            end
            CMD_LEN:
            begin
                if (sr.root > {1'b0, WORD_MAX})
                begin
                    osc_next  = WORD_MAX;
                    osat_next = 1'b1;
                end
                else
                    osc_next = sr.root[DATA_W-1:0];
            end
            CMD_EQ:
                oeq_next = sr.eq;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[NSIDE-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ov_reg   <= ov_next;
            osc_reg  <= osc_next;
            oeq_reg  <= oeq_next;
            osat_reg <= osat_next;
            odz_reg  <= odz_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_x          = ov_reg[0];
    assign out_y          = ov_reg[1];
    assign out_z          = ov_reg[2];
    assign out_w          = ov_reg[3];
    assign out_scalar     = osc_reg;
    assign equal          = oeq_reg;
    assign saturated      = osat_reg;
    assign divide_by_zero = odz_reg;

`ifndef ASSERT_OFF
    // an equality result carries no vector, no scalar and no flags
    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && equal |-> out_x == 0 && out_y == 0 && out_z == 0 && out_w == 0
                               && out_scalar == 0 && !saturated && !divide_by_zero)
        else $error("equal result with other fields set");

    // division by zero only comes from vector ops, so the scalar is zero
    a_dz_vector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> out_scalar == 0 && !equal)
        else $error("divide_by_zero on a scalar result");

    // a frozen pipeline must not lose the last stage's item
    a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
        !adv && v_reg[NSIDE-1] |=> v_reg[NSIDE-1] && out_valid)
        else $error("tail item lost while stalled");
`endif

endmodule
